@@ hdl/hermite_sample_rate_reducer_macros.svh @@
// Assertion macros shared by the sample-rate reducer RTL.
// Stand-alone header; define NO_ASSERTIONS to compile them out.
`ifndef HERMITE_SAMPLE_RATE_REDUCER_MACROS_SVH
`define HERMITE_SAMPLE_RATE_REDUCER_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define HSRR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// The consequent must hold in the cycle after the antecedent.
`define HSRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`else

`define HSRR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HSRR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/hsrr_pkg.sv @@
// Types, constants and the control store of the Hermite sample-rate reducer.
// No dependencies.
package hsrr_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned RateW   = 16;
  localparam int unsigned RemW    = RateW + 1;
  localparam int unsigned DivCntW = 4;
  localparam int unsigned CoefW   = 28;
  localparam int unsigned OpaW    = 30;
  localparam int unsigned ProdW   = OpaW + RateW + 1;
  localparam int unsigned SumW    = 48;
  localparam int unsigned VW      = SumW - 17;

  localparam logic [DivCntW-1:0] DivLast = DivCntW'(RateW - 1);

  localparam logic signed [VW-1:0] OutMax = VW'(8388607);
  localparam logic signed [VW-1:0] OutMin = -VW'(8388608);

  typedef enum logic [3:0] {
    STEP_IDLE,
    STEP_DIV,
    STEP_COEF,
    STEP_MUL_A,
    STEP_RND_A,
    STEP_MUL_B,
    STEP_RND_B,
    STEP_MUL_C,
    STEP_RND_C,
    STEP_EMIT
  } step_e;

  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_DIV,
    OP_COEF,
    OP_MUL,
    OP_RND_A,
    OP_RND_B,
    OP_RND_C,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    HOLD_NEVER,
    HOLD_NO_INPUT,
    HOLD_DIV_BUSY,
    HOLD_OUT_BLOCKED
  } hold_e;

  typedef struct packed {
    op_e   op;
    hold_e hold;
    step_e next;
  } ctrl_word_t;

  // Control store: while the hold condition is true the step repeats,
  // otherwise control moves to the next field.
  function automatic ctrl_word_t ucode_rom(step_e step);
    ctrl_word_t w;
    unique case (step)
      STEP_IDLE:  w = '{op: OP_ACCEPT, hold: HOLD_NO_INPUT,    next: STEP_DIV};
      STEP_DIV:   w = '{op: OP_DIV,    hold: HOLD_DIV_BUSY,    next: STEP_COEF};
      STEP_COEF:  w = '{op: OP_COEF,   hold: HOLD_NEVER,       next: STEP_MUL_A};
      STEP_MUL_A: w = '{op: OP_MUL,    hold: HOLD_NEVER,       next: STEP_RND_A};
      STEP_RND_A: w = '{op: OP_RND_A,  hold: HOLD_NEVER,       next: STEP_MUL_B};
      STEP_MUL_B: w = '{op: OP_MUL,    hold: HOLD_NEVER,       next: STEP_RND_B};
      STEP_RND_B: w = '{op: OP_RND_B,  hold: HOLD_NEVER,       next: STEP_MUL_C};
      STEP_MUL_C: w = '{op: OP_MUL,    hold: HOLD_NEVER,       next: STEP_RND_C};
      STEP_RND_C: w = '{op: OP_RND_C,  hold: HOLD_NEVER,       next: STEP_EMIT};
      STEP_EMIT:  w = '{op: OP_EMIT,   hold: HOLD_OUT_BLOCKED, next: STEP_IDLE};
      default:    w = '{op: OP_ACCEPT, hold: HOLD_NEVER,       next: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ hdl/hermite_sample_rate_reducer.sv @@
// Top level of the Hermite sample-rate reducer: microcoded sequencer and datapath.
// Depends on hsrr_pkg and hermite_sample_rate_reducer_macros.svh.

// Each accepted sample yields one output sample, a 4-point third-order Hermite
// interpolation over the held history at fraction phase/rate, saturated to 24 bits.
// An item passes from its input transfer to its result being ready through an accept
// step, the bit-serial restoring divider that forms the 16-bit fraction from phase
// and rate, a coefficient step, three passes of multiply and round through the single
// shared 30x17 multiplier, and the load of the output register. The next input
// transfer is taken in the cycle after that load, even while the result still waits
// downstream; a further result waits only if that one is still stalled.
// The rate register may be written through the configuration channel whenever the
// block is idle; cfg_ready_o is always high and a rate of zero acts as one.
`include "hermite_sample_rate_reducer_macros.svh"

module hermite_sample_rate_reducer
  import hsrr_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [SampleW-1:0] in_sample_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SampleW-1:0] out_sample_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic        [RateW-1:0]   cfg_data_i
);

  step_e      step_q, step_d;
  ctrl_word_t cw;
  logic       hold;

  logic [RateW-1:0]   rate_q;
  logic [RateW-1:0]   phase_q;
  logic signed [SampleW-1:0] hist_q [4];

  logic [RemW-1:0]    rem_q;
  logic [RateW-1:0]   quo_q;
  logic [RateW-1:0]   div_r_q;
  logic [DivCntW-1:0] div_cnt_q;

  logic signed [SampleW:0]   c1_q;
  logic signed [CoefW-1:0]   c2_q;
  logic signed [OpaW-1:0]    opa_q;
  logic signed [ProdW-1:0]   prod_q;
  logic signed [SampleW-1:0] res_q;
  logic signed [SampleW-1:0] out_q;
  logic                      out_valid_q;

  logic                 in_xfer;
  logic [RateW-1:0]     rate_eff;
  logic [RateW-1:0]     phase_eff;
  logic [RemW-1:0]      phase_inc;
  logic [RemW-1:0]      rem_shl;
  logic                 rem_ge;
  logic signed [CoefW-1:0] y0x, y1x, y2x, y3x;
  logic signed [SampleW:0] c1_d;
  logic signed [CoefW-1:0] c2_d, c3_d;
  logic signed [ProdW-1:0] prod_d;
  logic signed [SumW-1:0]  sum_a, sum_b, sum_c;
  logic signed [VW-1:0]    v_full;
  logic signed [SampleW-1:0] v_sat;

  // ---------------------------------------------------------------- control
  assign cw = ucode_rom(step_q);

  always_comb begin
    unique case (cw.hold)
      HOLD_NEVER:       hold = 1'b0;
      HOLD_NO_INPUT:    hold = !in_valid_i;
      HOLD_DIV_BUSY:    hold = (div_cnt_q != '0);
      HOLD_OUT_BLOCKED: hold = out_valid_q && out_stall_i;
      default:          hold = 1'b0;
    endcase
  end

  always_comb begin
    step_d = hold ? step_q : cw.next;
  end

  always_comb begin
    in_stall_o  = (cw.op != OP_ACCEPT);
    cfg_ready_o = 1'b1;
  end

  assign in_xfer      = in_valid_i && !in_stall_o;
  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // ---------------------------------------------------------- accept logic
  assign rate_eff  = (rate_q == '0) ? RateW'(1) : rate_q;
  assign phase_eff = (phase_q < rate_eff) ? phase_q : '0;
  assign phase_inc = {1'b0, phase_eff} + RemW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= RateW'(1);
      phase_q <= '0;
      for (int k = 0; k < 4; k++) begin
        hist_q[k] <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        rate_q <= cfg_data_i;
      end
      if (in_xfer) begin
        phase_q <= (phase_inc >= {1'b0, rate_eff}) ? '0 : phase_inc[RateW-1:0];
        if (phase_eff == '0) begin
          hist_q[0] <= hist_q[1];
          hist_q[1] <= hist_q[2];
          hist_q[2] <= hist_q[3];
          hist_q[3] <= in_sample_i;
        end
      end
    end
  end

  // --------------------------------------------------------------- divider
  // Restoring division of phase * 2^16 by the rate, one quotient bit a cycle.
  // The remainder starts below the divisor, so it always fits in RemW bits.
  assign rem_shl = {rem_q[RemW-2:0], 1'b0};
  assign rem_ge  = (rem_shl >= {1'b0, div_r_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cw.op == OP_ACCEPT && in_xfer) begin
      div_cnt_q <= DivLast;
    end else if (cw.op == OP_DIV && div_cnt_q != '0) begin
      div_cnt_q <= div_cnt_q - DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw.op == OP_ACCEPT && in_xfer) begin
      rem_q   <= {1'b0, phase_eff};
      quo_q   <= '0;
      div_r_q <= rate_eff;
    end else if (cw.op == OP_DIV) begin
      rem_q <= rem_ge ? (rem_shl - {1'b0, div_r_q}) : rem_shl;
      quo_q <= {quo_q[RateW-2:0], rem_ge};
    end
  end

  // -------------------------------------------------------------- datapath
  assign y0x = CoefW'(hist_q[0]);
  assign y1x = CoefW'(hist_q[1]);
  assign y2x = CoefW'(hist_q[2]);
  assign y3x = CoefW'(hist_q[3]);

  // Doubled Hermite coefficients, exact integers.
  assign c1_d = (SampleW+1)'(hist_q[2]) - (SampleW+1)'(hist_q[0]);
  assign c2_d = (y0x <<< 1) - ((y1x <<< 2) + y1x) + (y2x <<< 2) - y3x;
  assign c3_d = y3x - y0x + ((y1x - y2x) <<< 1) + (y1x - y2x);

  assign prod_d = ProdW'(opa_q) * ProdW'($signed({1'b0, quo_q}));

  assign sum_a = SumW'(prod_q) + (SumW'(c2_q) <<< 16) + SumW'(32768);
  assign sum_b = SumW'(prod_q) + (SumW'(c1_q) <<< 16) + SumW'(32768);
  assign sum_c = SumW'(prod_q) + (SumW'(hist_q[1]) <<< 17) + SumW'(65536);

  assign v_full = $signed(sum_c[SumW-1:17]);

  always_comb begin
    if (v_full > OutMax) begin
      v_sat = OutMax[SampleW-1:0];
    end else if (v_full < OutMin) begin
      v_sat = OutMin[SampleW-1:0];
    end else begin
      v_sat = v_full[SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cw.op)
      OP_COEF: begin
        c1_q  <= c1_d;
        c2_q  <= c2_d;
        opa_q <= OpaW'(c3_d);
      end
      OP_MUL:   prod_q <= prod_d;
      OP_RND_A: opa_q  <= $signed(sum_a[OpaW+15:16]);
      OP_RND_B: opa_q  <= $signed(sum_b[OpaW+15:16]);
      OP_RND_C: res_q  <= v_sat;
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cw.op == OP_EMIT && !hold) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw.op == OP_EMIT && !hold) begin
      out_q <= res_q;
    end
  end

  // ------------------------------------------------------------- assertions
  `HSRR_ASSERT_NEXT(a_accept_starts_div, clk_i, rst_ni, in_xfer,
                    (step_q == STEP_DIV) && (div_cnt_q == DivLast))
  `HSRR_ASSERT_IMPL(a_rem_below_divisor, clk_i, rst_ni, step_q == STEP_DIV,
                    rem_q < {1'b0, div_r_q})
  `HSRR_ASSERT_IMPL(a_result_from_emit, clk_i, rst_ni, $rose(out_valid_q),
                    $past(step_q) == STEP_EMIT)

endmodule
